// File: design/socks_client_handshake_defines.svh
// assertion helpers for the socks client handshake
`ifndef SOCKS_CLIENT_HANDSHAKE_DEFINES_SVH
`define SOCKS_CLIENT_HANDSHAKE_DEFINES_SVH

`define SCH_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("socks handshake check failed");

`define SCH_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
		else $error("socks handshake sequence check failed");

`endif

// File: design/sch_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sch_pkg;
	localparam int HostMaxDefault = 255;
	localparam int CredMaxDefault = 255;

	typedef enum logic [2:0] {
		REQ_START = 3'd0,
		REQ_HOST  = 3'd1,
		REQ_USER  = 3'd2,
		REQ_PASS  = 3'd3,
		REQ_RX    = 3'd4,
		REQ_SLOT  = 3'd5
	} req_type_t;

	typedef enum logic [3:0] {
		PH_LOAD, PH_S4_REQ, PH_S4_REP, PH_M_REQ, PH_M_REP, PH_AU_REQ, PH_AP_REQ,
		PH_A_REP, PH_C_REQ, PH_C_REP, PH_C_DLEN, PH_SKIP, PH_DONE_T, PH_DONE_H,
		PH_FAIL
	} phase_t;

	localparam logic [2:0] ST_LOADING = 3'd0;
	localparam logic [2:0] ST_BUSY    = 3'd1;
	localparam logic [2:0] ST_TUNNEL  = 3'd2;
	localparam logic [2:0] ST_HTTP    = 3'd3;
	localparam logic [2:0] ST_FAILED  = 3'd4;

	localparam logic [2:0] ERR_NONE     = 3'd0;
	localparam logic [2:0] ERR_HOST     = 3'd1;
	localparam logic [2:0] ERR_PROXY    = 3'd2;
	localparam logic [2:0] ERR_VERSION  = 3'd3;
	localparam logic [2:0] ERR_REJECT   = 3'd4;
	localparam logic [2:0] ERR_AUTH     = 3'd5;
	localparam logic [2:0] ERR_ADDRTYPE = 3'd6;

	localparam logic [1:0] KIND_S4 = 2'd0;
	localparam logic [1:0] KIND_S5 = 2'd1;

	localparam logic [0:0] CFG_KIND   = 1'b0;
	localparam logic [0:0] CFG_TUNNEL = 1'b1;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic [15:0] dest_port;
	} sch_in_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       tx_last;
		logic [2:0] status;
		logic [2:0] error_code;
	} sch_out_t;

	// which store a byte request reads
	typedef enum logic [1:0] {
		SRC_NONE, SRC_HOST, SRC_USER, SRC_PASS
	} src_t;
endpackage
`default_nettype wire

// File: design/sch_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sch_in_if;
	import sch_pkg::*;
	logic    valid;
	logic    ready;
	sch_in_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface sch_out_if;
	import sch_pkg::*;
	logic     valid;
	logic     ready;
	sch_out_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: design/socks_client_handshake.sv
`timescale 1ns / 1ps
`default_nettype none
// SOCKS4a / SOCKS5 client handshake engine, CONNECT by domain name.
// in_ch carries one item per transfer: a host, user or password byte to
// load, a start (with dest_port), a received byte, or a send slot.
// out_ch gives exactly one result per input item, in order: the request
// byte for a send slot (tx_valid, tx_byte, tx_last) plus status and error.
// Stage 1 registers the item and the phase update and issues the store
// read; the next edge writes the result into a four-entry output queue.
// One item is taken every cycle while in_ch is ready.
// The three byte stores are synchronous memories, one read port each; a
// loaded byte is never read in the cycle it is written (loading and
// sending cannot overlap), so no forwarding is needed.
// When out_ch stalls, results collect in the output queue; in_ch drops
// ready once the queued results plus the one in stage 1 fill the queue.
// Reset (arst_n low) returns to loading with all lengths cleared, the
// proxy kind at SOCKS4a and tunnel_mode 0; store contents are kept.
// cfg_we/cfg_index/cfg_data write proxy_kind (0) and tunnel_mode (1).
module socks_client_handshake #(
	parameter int HostMax = sch_pkg::HostMaxDefault,
	parameter int CredMax = sch_pkg::CredMaxDefault
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	sch_in_if.sink          in_ch,
	sch_out_if.source       out_ch,
	input  wire logic       cfg_we,
	input  wire logic [0:0] cfg_index,
	input  wire logic [1:0] cfg_data
);
	import sch_pkg::*;
	`include "socks_client_handshake_defines.svh"

	logic [7:0] host_mem [256];
	logic [7:0] user_mem [256];
	logic [7:0] pass_mem [256];

	logic [1:0] kind_q;
	logic       tunnel_q;
	phase_t     phase_q, phase_d;
	logic [8:0] cnt_q, cnt_d;
	logic [8:0] hlen_q, hlen_d;
	logic [7:0] ulen_q, ulen_d, plen_q, plen_d;
	logic       upres_q, upres_d, uwrap_q, uwrap_d, pwrap_q, pwrap_d;
	logic [15:0] port_q, port_d;
	logic [8:0] skip_q, skip_d;
	logic [7:0] rx0_q, rx0_d, rx1_q, rx1_d;
	logic [2:0] err_q, err_d;

	// stage 1 result fields
	logic       v_s1, tv_s1, tl_s1;
	logic [7:0] tb_s1;
	src_t       src_s1;
	logic [2:0] st_s1, er_s1;
	logic       tv_d, tl_d;
	logic [7:0] tb_d;
	src_t       src_d;
	logic [7:0] raddr_d;
	logic [7:0] hrd_q, urd_q, prd_q;

	sch_out_t   res_w;
	sch_out_t   oq_mem_q [4];
	logic [2:0] oq_cnt_q;
	logic [1:0] oq_rd_q, oq_wr_q;
	logic       pop;
	logic       accept;
	logic       load_we;

	// room for the stage 1 result and one more transfer
	assign in_ch.ready = (oq_cnt_q + 3'(v_s1)) < 3'd4;
	assign accept = in_ch.valid && in_ch.ready;
	assign out_ch.valid = oq_cnt_q != 3'd0;
	assign out_ch.payload = oq_mem_q[oq_rd_q];
	assign pop = out_ch.valid && out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= KIND_S4;
			tunnel_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_KIND) kind_q <= cfg_data;
			else tunnel_q <= cfg_data[0];
		end
	end

	function automatic logic is_loading(phase_t p);
		return p == PH_LOAD || p == PH_DONE_T || p == PH_DONE_H || p == PH_FAIL;
	endfunction
	function automatic logic is_sending(phase_t p);
		return p == PH_S4_REQ || p == PH_M_REQ || p == PH_AU_REQ ||
			p == PH_AP_REQ || p == PH_C_REQ;
	endfunction

	always_comb begin
		logic [2:0] t;
		logic [7:0] d;
		logic [8:0] len, i, hl, nx;
		phase_t fin;
		t = in_ch.payload.req_type;
		d = in_ch.payload.data_byte;
		phase_d = phase_q; cnt_d = cnt_q; hlen_d = hlen_q; ulen_d = ulen_q;
		plen_d = plen_q; upres_d = upres_q; uwrap_d = uwrap_q; pwrap_d = pwrap_q;
		port_d = port_q; skip_d = skip_q; rx0_d = rx0_q; rx1_d = rx1_q; err_d = err_q;
		tv_d = 1'b0; tb_d = 8'd0; tl_d = 1'b0; src_d = SRC_NONE; raddr_d = 8'd0;
		load_we = 1'b0;
		len = 9'd0; i = cnt_q; hl = hlen_q; nx = 9'd0;
		fin = tunnel_q ? PH_DONE_T : PH_DONE_H;
		if (t >= REQ_HOST && t <= REQ_PASS && is_loading(phase_q)) begin
			load_we = 1'b1;
			if (phase_q != PH_LOAD) begin
				hlen_d = '0; ulen_d = '0; plen_d = '0;
				upres_d = 1'b0; uwrap_d = 1'b0; pwrap_d = 1'b0;
				phase_d = PH_LOAD; err_d = ERR_NONE;
			end
			if (t == REQ_HOST) begin
				if (hlen_d <= 9'(HostMax)) hlen_d = hlen_d + 9'd1;
			end else if (t == REQ_USER) begin
				upres_d = 1'b1;
				ulen_d = ulen_d + 8'd1;
				if (ulen_d == 8'd0) uwrap_d = 1'b1;
			end else begin
				plen_d = plen_d + 8'd1;
				if (plen_d == 8'd0) pwrap_d = 1'b1;
			end
		end else if (t == REQ_START) begin
			err_d = ERR_NONE;
			port_d = in_ch.payload.dest_port;
			cnt_d = '0; skip_d = '0;
			if (kind_q == KIND_S4) begin
				if (hlen_q > 9'(HostMax)) begin phase_d = PH_FAIL; err_d = ERR_HOST; end
				else phase_d = PH_S4_REQ;
			end else if (kind_q == KIND_S5) phase_d = PH_M_REQ;
			else begin phase_d = PH_FAIL; err_d = ERR_PROXY; end
		end else if (t == REQ_SLOT && is_sending(phase_q)) begin
			tv_d = 1'b1;
			case (phase_q)
				PH_S4_REQ: begin
					len = 9'd10 + hl;
					case (i)
						9'd0: tb_d = 8'd4;
						9'd1, 9'd7: tb_d = 8'd1;
						9'd2: tb_d = port_q[15:8];
						9'd3: tb_d = port_q[7:0];
						default: begin
							if (i >= 9'd9 && i < 9'd9 + hl && (i - 9'd9) < 9'(HostMax)) begin
								src_d = SRC_HOST; raddr_d = 8'(i - 9'd9);
							end
						end
					endcase
				end
				PH_M_REQ: begin
					len = upres_q ? 9'd4 : 9'd3;
					case (i)
						9'd0: tb_d = 8'd5;
						9'd1: tb_d = upres_q ? 8'd2 : 8'd1;
						9'd3: tb_d = 8'd2;
						default: tb_d = 8'd0;
					endcase
				end
				PH_AU_REQ: begin
					len = 9'd2 + 9'(ulen_q);
					if (i == 9'd0) tb_d = 8'd1;
					else if (i == 9'd1) tb_d = ulen_q;
					else if ((i - 9'd2) < 9'(CredMax)) begin
						src_d = SRC_USER; raddr_d = 8'(i - 9'd2);
					end
				end
				PH_AP_REQ: begin
					len = 9'd1 + 9'(plen_q);
					if (i == 9'd0) tb_d = plen_q;
					else if ((i - 9'd1) < 9'(CredMax)) begin
						src_d = SRC_PASS; raddr_d = 8'(i - 9'd1);
					end
				end
				default: begin
					len = 9'd7 + hl;
					case (i)
						9'd0: tb_d = 8'd5;
						9'd1: tb_d = 8'd1;
						9'd2: tb_d = 8'd0;
						9'd3: tb_d = 8'd3;
						9'd4: tb_d = hl[7:0];
						default: begin
							if (i < 9'd5 + hl) begin
								if ((i - 9'd5) < 9'(HostMax)) begin
									src_d = SRC_HOST; raddr_d = 8'(i - 9'd5);
								end
							end else if (i == 9'd5 + hl) tb_d = port_q[15:8];
							else tb_d = port_q[7:0];
						end
					endcase
				end
			endcase
			nx = cnt_q + 9'd1;
			if (nx >= len) begin
				tl_d = 1'b1; cnt_d = '0;
				case (phase_q)
					PH_S4_REQ: phase_d = PH_S4_REP;
					PH_M_REQ: phase_d = PH_M_REP;
					PH_AU_REQ: phase_d = PH_AP_REQ;
					PH_AP_REQ: phase_d = PH_A_REP;
					default: phase_d = PH_C_REP;
				endcase
			end else cnt_d = nx;
		end else if (t == REQ_RX && !is_loading(phase_q) && !is_sending(phase_q)) begin
			if (phase_q == PH_C_DLEN) begin
				skip_d = 9'(d) + 9'd2; phase_d = PH_SKIP;
			end else if (phase_q == PH_SKIP) begin
				if (skip_q != 9'd0) skip_d = skip_q - 9'd1;
				if (skip_d == 9'd0) begin phase_d = fin; cnt_d = '0; end
			end else begin
				if (cnt_q == 9'd0) rx0_d = d;
				else if (cnt_q == 9'd1) rx1_d = d;
				case (phase_q)
					PH_S4_REP: begin
						if (cnt_q < 9'd7) cnt_d = cnt_q + 9'd1;
						else begin
							cnt_d = '0;
							if (rx0_d != 8'd0) begin phase_d = PH_FAIL; err_d = ERR_VERSION; end
							else if (rx1_d != 8'd90) begin
								phase_d = PH_FAIL; err_d = ERR_REJECT;
							end else phase_d = fin;
						end
					end
					PH_M_REP, PH_A_REP: begin
						if (cnt_q < 9'd1) cnt_d = cnt_q + 9'd1;
						else begin
							cnt_d = '0;
							if (phase_q == PH_M_REP && rx0_d != 8'd5) begin
								phase_d = PH_FAIL; err_d = ERR_VERSION;
							end else if (phase_q == PH_M_REP && rx1_d == 8'd2) phase_d = PH_AU_REQ;
							else if (phase_q == PH_M_REP && rx1_d != 8'd0) begin
								phase_d = PH_FAIL; err_d = ERR_REJECT;
							end else if (phase_q == PH_A_REP &&
								(rx1_d != 8'd0 || !(rx0_d == 8'd5 || rx0_d == 8'd1))) begin
								phase_d = PH_FAIL; err_d = ERR_AUTH;
							end else if (hlen_q > 9'(HostMax)) begin
								phase_d = PH_FAIL; err_d = ERR_HOST;
							end else phase_d = PH_C_REQ;
						end
					end
					default: begin
						if (cnt_q < 9'd3) cnt_d = cnt_q + 9'd1;
						else begin
							cnt_d = '0;
							if (rx0_d != 8'd5) begin phase_d = PH_FAIL; err_d = ERR_VERSION; end
							else if (rx1_d != 8'd0) begin
								phase_d = PH_FAIL; err_d = ERR_REJECT;
							end else if (d == 8'd1) begin skip_d = 9'd6; phase_d = PH_SKIP; end
							else if (d == 8'd4) begin skip_d = 9'd18; phase_d = PH_SKIP; end
							else if (d == 8'd3) phase_d = PH_C_DLEN;
							else begin phase_d = PH_FAIL; err_d = ERR_ADDRTYPE; end
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LOAD; cnt_q <= '0; hlen_q <= '0; ulen_q <= '0; plen_q <= '0;
			upres_q <= 1'b0; uwrap_q <= 1'b0; pwrap_q <= 1'b0; port_q <= '0;
			skip_q <= '0; rx0_q <= '0; rx1_q <= '0; err_q <= ERR_NONE;
			v_s1 <= 1'b0;
		end else begin
			if (accept) begin
				phase_q <= phase_d; cnt_q <= cnt_d; hlen_q <= hlen_d; ulen_q <= ulen_d;
				plen_q <= plen_d; upres_q <= upres_d; uwrap_q <= uwrap_d;
				pwrap_q <= pwrap_d; port_q <= port_d; skip_q <= skip_d;
				rx0_q <= rx0_d; rx1_q <= rx1_d; err_q <= err_d;
			end
			v_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			tv_s1 <= tv_d; tb_s1 <= tb_d; tl_s1 <= tl_d; src_s1 <= src_d;
			case (phase_d)
				PH_LOAD: st_s1 <= ST_LOADING;
				PH_DONE_T: st_s1 <= ST_TUNNEL;
				PH_DONE_H: st_s1 <= ST_HTTP;
				PH_FAIL: st_s1 <= ST_FAILED;
				default: st_s1 <= ST_BUSY;
			endcase
			er_s1 <= (phase_d == PH_FAIL) ? err_d : ERR_NONE;
		end
	end

	// byte stores: one write port for loading, one registered read port
	always_ff @(posedge clk) begin
		if (accept && load_we) begin
			if (in_ch.payload.req_type == REQ_HOST && hlen_d <= 9'(HostMax) &&
				hlen_d != 9'd0 && (hlen_d - 9'd1) < 9'(HostMax))
				host_mem[8'(hlen_d - 9'd1)] <= in_ch.payload.data_byte;
			if (in_ch.payload.req_type == REQ_USER && !uwrap_d &&
				9'(ulen_d) - 9'd1 < 9'(CredMax) && ulen_d != 8'd0)
				user_mem[ulen_d - 8'd1] <= in_ch.payload.data_byte;
			if (in_ch.payload.req_type == REQ_PASS && !pwrap_d &&
				9'(plen_d) - 9'd1 < 9'(CredMax) && plen_d != 8'd0)
				pass_mem[plen_d - 8'd1] <= in_ch.payload.data_byte;
		end
		hrd_q <= host_mem[raddr_d];
		urd_q <= user_mem[raddr_d];
		prd_q <= pass_mem[raddr_d];
	end

	always_comb begin
		res_w.tx_valid = tv_s1;
		res_w.tx_last = tl_s1;
		res_w.status = st_s1;
		res_w.error_code = er_s1;
		case (src_s1)
			SRC_HOST: res_w.tx_byte = hrd_q;
			SRC_USER: res_w.tx_byte = urd_q;
			SRC_PASS: res_w.tx_byte = prd_q;
			default: res_w.tx_byte = tb_s1;
		endcase
	end

	// output queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_cnt_q <= '0;
			oq_rd_q <= '0;
			oq_wr_q <= '0;
		end else begin
			if (v_s1) oq_wr_q <= oq_wr_q + 2'd1;
			if (pop) oq_rd_q <= oq_rd_q + 2'd1;
			if (v_s1 && !pop) oq_cnt_q <= oq_cnt_q + 3'd1;
			else if (!v_s1 && pop) oq_cnt_q <= oq_cnt_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) oq_mem_q[oq_wr_q] <= res_w;
	end

	`SCH_ASSERT(a_queue_room, clk, arst_n, !v_s1 || oq_cnt_q < 3'd4)
	`SCH_ASSERT_NEXT(a_full_holds, clk, arst_n, oq_cnt_q == 3'd4 && !out_ch.ready,
		oq_cnt_q == 3'd4)
	`SCH_ASSERT(a_err_only_fail, clk, arst_n,
		!out_ch.valid || out_ch.payload.status == ST_FAILED ||
		out_ch.payload.error_code == ERR_NONE)
endmodule
`default_nettype wire
